// ===== design/binary_fsk_modulator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary FSK modulator checker.
// Both expect signals named clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef BINARY_FSK_MODULATOR_CORE_MACROS_SVH
`define BINARY_FSK_MODULATOR_CORE_MACROS_SVH

// same-cycle implication
`define BFSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bfsk_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsk_pkg
// Shared types, constants and the quarter-wave table generator for the
// binary FSK modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsk_pkg;

    // default sizes
    localparam int MAX_FRAME_BITS_DEF = 4096;
    localparam int TABLE_ENTRIES_DEF  = 256;
    localparam int SAMPLE_BITS_DEF    = 16;

    // configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_TONE_STEP  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_TONE_STEP = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_STEP    = 2'd2;

    // register reset values
    localparam logic [31:0] LOW_TONE_STEP_RST  = 32'd419188808;
    localparam logic [31:0] HIGH_TONE_STEP_RST = 32'd439804651;
    localparam logic [31:0] SYMBOL_STEP_RST    = 32'd41231686;

    // command opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // transmitter mode
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WAIT = 3'b010,
        MODE_SEND = 3'b100
    } tx_mode_t;

    // pi/2 in unsigned Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2n)(2n+1) for n = 1..8
    localparam longint unsigned TAYLOR_DIV [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Quarter-wave entry k: amplitude * sin(pi/2 * (2k+1) / (2N)), N = 2^log2_entries.
    // Odd series to x^17 in Q30, products truncated, final scale rounds half up.
    // Evaluated only with constant arguments.
    function automatic longint unsigned quarter_sine(
        input int unsigned k,
        input int unsigned log2_entries,
        input int unsigned sample_bits
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned amp;
        x     = (HALF_PI_Q30 * (2 * longint'(k) + 1)) >> (log2_entries + 1);
        x2    = (x * x) >> 30;
        term  = x;
        plus  = x;
        minus = 64'd0;
        amp   = (64'd1 << (sample_bits - 1)) - 64'd1;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                minus = minus + term;
            end
            else begin
                plus = plus + term;
            end
        end
        plus = (plus > minus) ? plus - minus : 64'd0;
        return (plus * amp + (64'd1 << 29)) >> 30;
    endfunction

endpackage

`default_nettype wire

// ===== design/bfsk_ifs.sv =====
// ----------------------------------------------------------------------------
// bfsk channel interfaces
// Command, sample and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

// command channel: bit loads and sample ticks
interface bfsk_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        bit_value;
    logic        last_bit;
    logic [63:0] start_time;
    logic [63:0] now_time;

    modport source (output valid, output opcode, output bit_value, output last_bit,
                    output start_time, output now_time, input ready);
    modport sink   (input valid, input opcode, input bit_value, input last_bit,
                    input start_time, input now_time, output ready);
endinterface

// sample channel: one result per tick
interface bfsk_smp_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic                          active;
    logic                          frame_done;

    modport source (output valid, output sample_i, output sample_q, output active,
                    output frame_done, input ready);
    modport sink   (input valid, input sample_i, input sample_q, input active,
                    input frame_done, output ready);
endinterface

// configuration write channel
interface bfsk_cfg_if #(
    parameter int INDEX_BITS = 2
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] index;
    logic [31:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/binary_fsk_modulator_core.sv =====
// ----------------------------------------------------------------------------
// binary_fsk_modulator_core
// Binary FSK modulator: frame bit store, start-time gate, carrier NCO with
// quarter-wave table and symbol-rate accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries bit loads (opcode 0) and sample ticks (opcode 1). Loads are
//   taken while idle; the bit marked last latches start_time and arms the
//   frame. Each tick gives exactly one request on smp; loads give none.
//   cfg writes the low/high tone steps and the symbol step; it is always
//   ready. The user must write it only while the block is idle; the block
//   does not enforce this. Throughput: one command per clock, unless a
//   tick is held by a stalled smp. A command is registered in the input
//   register when accepted and processed from there into the smp output
//   register. The bit store read is registered and addressed ahead with
//   the next bit position, with a bypass for a write to the same entry.
//   Reset: idle, phases and start time zero, steps at their defaults. The
//   bit store is not cleared; only bits of the current frame are read.
//   Stall: smp holds its request until taken. A tick waiting in the input
//   register then holds and cmd ready drops; loads keep draining.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_fsk_modulator_core #(
    parameter int MAX_FRAME_BITS = bfsk_pkg::MAX_FRAME_BITS_DEF,
    parameter int TABLE_ENTRIES  = bfsk_pkg::TABLE_ENTRIES_DEF,
    parameter int SAMPLE_BITS    = bfsk_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bfsk_cmd_if.sink    cmd,
    bfsk_smp_if.source  smp,
    bfsk_cfg_if.sink    cfg
);
    import bfsk_pkg::*;

    localparam int LEN_BITS  = $clog2(MAX_FRAME_BITS + 1);
    localparam int ADDR_BITS = $clog2(MAX_FRAME_BITS);
    localparam int TAB_BITS  = $clog2(TABLE_ENTRIES);
    localparam int IDX_BITS  = TAB_BITS + 2;
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(MAX_FRAME_BITS);

    // configuration
    logic [31:0] low_step_reg;
    logic [31:0] high_step_reg;
    logic [31:0] sym_step_reg;

    // input register
    logic        cmd_valid_reg;
    logic        opcode_reg;
    logic        bit_reg;
    logic        last_reg;
    logic [63:0] start_reg;
    logic [63:0] now_reg;

    // block state
    tx_mode_t            mode_reg, mode_next, mode_eff;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_BITS-1:0] pos_reg, pos_next;
    logic [31:0]         sym_reg, sym_next;
    logic [31:0]         car_reg, car_next;
    logic [63:0]         fstart_reg, fstart_next;

    // output register
    logic                          smp_valid_reg;
    logic signed [SAMPLE_BITS-1:0] smp_i_reg, smp_i_next;
    logic signed [SAMPLE_BITS-1:0] smp_q_reg, smp_q_next;
    logic                          smp_act_reg, smp_act_next;
    logic                          smp_done_reg, smp_done_next;

    // bit store
    logic                 frame_mem [MAX_FRAME_BITS];
    logic                 rd_bit_reg;
    logic                 byp_hit_reg;
    logic                 byp_bit_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 mem_we;
    logic                 cur_bit;

    // datapath
    logic                          out_free;
    logic                          advance;
    logic                          do_load;
    logic                          do_tick;
    logic [63:0]                   time_diff;
    logic [31:0]                   tone_step;
    logic [31:0]                   car_sum;
    logic [32:0]                   sym_sum;
    logic [IDX_BITS-1:0]           phase_idx;
    logic [1:0]                    quad;
    logic [TAB_BITS-1:0]           tab_pos;
    logic signed [SAMPLE_BITS-1:0] tab_a;
    logic signed [SAMPLE_BITS-1:0] tab_b;
    logic signed [SAMPLE_BITS-1:0] sin_val;
    logic signed [SAMPLE_BITS-1:0] cos_val;
    logic signed [SAMPLE_BITS-1:0] sine_rom [TABLE_ENTRIES];

    // quarter-wave table, constant
    always_comb
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            sine_rom[k] = SAMPLE_BITS'(quarter_sine(k, TAB_BITS, SAMPLE_BITS));
        end
    end

    // handshake
    assign out_free  = !smp_valid_reg || smp.ready;
    assign advance   = cmd_valid_reg && ((opcode_reg == OP_LOAD) || out_free);
    assign do_load   = advance && (opcode_reg == OP_LOAD);
    assign do_tick   = advance && (opcode_reg == OP_TICK);
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_step_reg  <= LOW_TONE_STEP_RST;
            high_step_reg <= HIGH_TONE_STEP_RST;
            sym_step_reg  <= SYMBOL_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LOW_TONE_STEP:  low_step_reg  <= cfg.data;
                REG_HIGH_TONE_STEP: high_step_reg <= cfg.data;
                REG_SYMBOL_STEP:    sym_step_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            opcode_reg <= cmd.opcode;
            bit_reg    <= cmd.bit_value;
            last_reg   <= cmd.last_bit;
            start_reg  <= cmd.start_time;
            now_reg    <= cmd.now_time;
        end
    end

    // NCO and table lookup for the new carrier phase
    assign cur_bit   = byp_hit_reg ? byp_bit_reg : rd_bit_reg;
    assign tone_step = cur_bit ? high_step_reg : low_step_reg;
    assign car_sum   = car_reg + tone_step;
    assign sym_sum   = {1'b0, sym_reg} + {1'b0, sym_step_reg};
    assign phase_idx = car_sum[31 -: IDX_BITS];
    assign quad      = phase_idx[IDX_BITS-1 -: 2];
    assign tab_pos   = phase_idx[TAB_BITS-1:0];
    assign tab_a     = sine_rom[tab_pos];
    assign tab_b     = sine_rom[~tab_pos];
    assign time_diff = now_reg - fstart_reg;

    // quadrant folding
    always_comb
    begin
        case (quad)
            2'd0:    begin sin_val = tab_a;  cos_val = tab_b;  end
            2'd1:    begin sin_val = tab_b;  cos_val = -tab_a; end
            2'd2:    begin sin_val = -tab_a; cos_val = -tab_b; end
            default: begin sin_val = -tab_b; cos_val = tab_a;  end
        endcase
    end

    // state update for one command
    always_comb
    begin
        mode_next     = mode_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        sym_next      = sym_reg;
        car_next      = car_reg;
        fstart_next   = fstart_reg;
        mem_we        = 1'b0;
        smp_i_next    = '0;
        smp_q_next    = '0;
        smp_act_next  = 1'b0;
        smp_done_next = 1'b0;
        mode_eff      = mode_reg;

        if (do_load)
        begin
            // loads only while idle (or an unknown mode)
            if (mode_reg != MODE_WAIT && mode_reg != MODE_SEND)
            begin
                if (len_reg < MAX_LEN)
                begin
                    mem_we   = 1'b1;
                    len_next = len_reg + 1'b1;
                end
                if (last_reg)
                begin
                    fstart_next = start_reg;
                    pos_next    = '0;
                    mode_next   = MODE_WAIT;
                end
            end
        end
        else if (do_tick)
        begin
            // start gate: signed difference no longer negative
            if (mode_reg == MODE_WAIT && !time_diff[63])
            begin
                mode_eff = MODE_SEND;
            end
            mode_next = mode_eff;

            if (mode_eff == MODE_SEND)
            begin
                if (pos_reg >= len_reg || pos_reg >= MAX_LEN)
                begin
                    // frame end
                    mode_next     = MODE_IDLE;
                    len_next      = '0;
                    pos_next      = '0;
                    smp_done_next = 1'b1;
                end
                else
                begin
                    car_next     = car_sum;
                    sym_next     = sym_sum[31:0];
                    if (sym_sum[32])
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    smp_i_next   = cos_val;
                    smp_q_next   = sin_val;
                    smp_act_next = 1'b1;
                end
            end
        end
    end

    // block state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            len_reg    <= '0;
            pos_reg    <= '0;
            sym_reg    <= '0;
            car_reg    <= '0;
            fstart_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sym_reg    <= sym_next;
            car_reg    <= car_next;
            fstart_reg <= fstart_next;
        end
    end

    // bit store: registered read, addressed ahead at the next bit position
    assign wr_addr = len_reg[ADDR_BITS-1:0];
    assign rd_addr = pos_next[ADDR_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[wr_addr] <= bit_reg;
        end
        rd_bit_reg  <= frame_mem[rd_addr];
        byp_hit_reg <= mem_we && (wr_addr == rd_addr);
        byp_bit_reg <= bit_reg;
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            smp_valid_reg <= do_tick;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (do_tick)
        begin
            smp_i_reg    <= smp_i_next;
            smp_q_reg    <= smp_q_next;
            smp_act_reg  <= smp_act_next;
            smp_done_reg <= smp_done_next;
        end
    end

    assign smp.valid      = smp_valid_reg;
    assign smp.sample_i   = smp_i_reg;
    assign smp.sample_q   = smp_q_reg;
    assign smp.active     = smp_act_reg;
    assign smp.frame_done = smp_done_reg;

endmodule

`default_nettype wire

// ===== design/bfsk_checker.sv =====
// ----------------------------------------------------------------------------
// bfsk_checker
// Port-level checks on the binary FSK modulator, bound to binary_fsk_modulator_core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_fsk_modulator_core_macros.svh"

module bfsk_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_ready,
    input wire logic                          smp_valid,
    input wire logic                          smp_ready,
    input wire logic signed [SAMPLE_BITS-1:0] sample_i,
    input wire logic signed [SAMPLE_BITS-1:0] sample_q,
    input wire logic                          active,
    input wire logic                          frame_done
);

    // a stalled sample request keeps its value
    `BFSK_ASSERT_NEXT(a_smp_hold, smp_valid && !smp_ready, smp_valid && $stable(sample_i) && $stable(sample_q) && $stable(active) && $stable(frame_done), "sample request changed while stalled")

    // with an empty output register the command side never stalls
    `BFSK_ASSERT_NOW(a_cmd_ready_free, !smp_valid, cmd_ready, "command stalled with free output")

    // the end-of-frame request carries no sample
    `BFSK_ASSERT_NOW(a_done_not_active, smp_valid && frame_done, !active, "frame_done with active")

    // inactive requests are silent
    `BFSK_ASSERT_NOW(a_idle_zero, smp_valid && !active, sample_i == '0 && sample_q == '0, "nonzero sample while inactive")

endmodule

bind binary_fsk_modulator_core bfsk_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_bfsk_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .smp_valid  (smp.valid),
    .smp_ready  (smp.ready),
    .sample_i   (smp.sample_i),
    .sample_q   (smp.sample_q),
    .active     (smp.active),
    .frame_done (smp.frame_done)
);

`default_nettype wire
